[design/rgd_pkg.sv]
package rgd_pkg;

  // Coefficient format: signed Q3.16
  localparam int COEF_BITS = 20;
  localparam int FRAC_BITS = 16;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_GAIN      = 3'd0,
    CFG_FEEDBACK_ONE   = 3'd1,
    CFG_FEEDBACK_TWO   = 3'd2,
    CFG_FEEDBACK_THREE = 3'd3,
    CFG_REVERSE_MODE   = 3'd4
  } cfg_idx_e;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef struct packed {
    coef_t diff_gain;
    coef_t feedback_one;
    coef_t feedback_two;
    coef_t feedback_three;
  } coef_set_t;

endpackage

[design/rgd_if.sv]
interface rgd_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          line_start;

  modport source (output valid, output sample, output line_start, input ready);
  modport sink   (input valid, input sample, input line_start, output ready);
endinterface

interface rgd_out_if #(
  parameter int OUTPUT_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [OUTPUT_BITS-1:0] filtered;
  logic                          saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

interface rgd_cfg_if
  import rgd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/rgd_datapath.sv]
module rgd_datapath
  import rgd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int OUTPUT_BITS = 24,
  parameter int HIST_BITS   = 24
) (
  input  coef_set_t                     coef_i,
  input  logic signed [SAMPLE_BITS:0]   diff_i,
  input  logic signed [HIST_BITS-1:0]   tap0_i,
  input  logic signed [HIST_BITS-1:0]   tap1_i,
  input  logic signed [HIST_BITS-1:0]   tap2_i,
  output logic signed [OUTPUT_BITS-1:0] filtered_o,
  output logic                          saturated_o
);

  localparam int PD_W  = COEF_BITS + SAMPLE_BITS + 1;
  localparam int PF_W  = COEF_BITS + HIST_BITS;
  // three guard bits: four-term sum plus the rounding half
  localparam int ACC_W = ((PD_W > PF_W) ? PD_W : PF_W) + 3;
  localparam int RND_W = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [RND_W-1:0] MAXV =
    {{(RND_W-OUTPUT_BITS+1){1'b0}}, {(OUTPUT_BITS-1){1'b1}}};
  localparam logic signed [RND_W-1:0] MINV = ~MAXV;

  logic signed [PD_W-1:0]  prod_d;
  logic signed [PF_W-1:0]  prod_1;
  logic signed [PF_W-1:0]  prod_2;
  logic signed [PF_W-1:0]  prod_3;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_biased;
  logic signed [RND_W-1:0] rounded;

  assign prod_d = coef_i.diff_gain      * diff_i;
  assign prod_1 = coef_i.feedback_one   * tap0_i;
  assign prod_2 = coef_i.feedback_two   * tap1_i;
  assign prod_3 = coef_i.feedback_three * tap2_i;

  assign acc = ACC_W'(prod_d) + ACC_W'(prod_1) + ACC_W'(prod_2) + ACC_W'(prod_3);

  // round half up: add one half, then floor by dropping the fraction
  assign acc_biased = acc + HALF;
  assign rounded    = acc_biased[ACC_W-1:FRAC_BITS];

  always_comb begin
    priority if (rounded > MAXV) begin
      filtered_o  = MAXV[OUTPUT_BITS-1:0];
      saturated_o = 1'b1;
    end else if (rounded < MINV) begin
      filtered_o  = MINV[OUTPUT_BITS-1:0];
      saturated_o = 1'b1;
    end else begin
      filtered_o  = rounded[OUTPUT_BITS-1:0];
      saturated_o = 1'b0;
    end
  end

endmodule

[design/recursive_gaussian_derivative_line.sv]
// Third-order recursive line filter with a first-difference input term.
// in_ch carries one sample per transfer with a line_start flag; out_ch
// returns one filtered value and a saturation flag for every sample, in order.
// cfg_ch writes the coefficients and the reverse_mode bit; it is always ready
// and should only be used while no sample is in flight.
// A transferred sample passes the input register, then the filter arithmetic into
// the result register, and shows its result on out_ch from there. Throughput:
// one sample per cycle while out_ch does not stall, set by the feedback loop of
// four multiplies, a four-term sum, rounding and saturation that closes
// combinationally from the history registers back to themselves.
// Reset clears the coefficients, reverse_mode, the sample and output history
// and the valid flags of both pipeline registers. When the receiver stalls,
// the result register holds its value, the input register still takes one
// more sample, and in_ch.ready then drops until out_ch transfers.
// A line_start sample loads the previous sample and all three history taps
// with itself before filtering; before the first line_start the zero history
// from reset is used.
module recursive_gaussian_derivative_line
  import rgd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int OUTPUT_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rgd_in_if.sink        in_ch,
  rgd_out_if.source     out_ch,
  rgd_cfg_if.sink       cfg_ch
);

  localparam int HIST_BITS = (SAMPLE_BITS > OUTPUT_BITS) ? SAMPLE_BITS : OUTPUT_BITS;

  coef_set_t coef_q;
  logic      reverse_q;

  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic                          s1_start_q;

  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [HIST_BITS-1:0]   tap_q [3];

  logic                          out_valid_q;
  logic signed [OUTPUT_BITS-1:0] out_filtered_q;
  logic                          out_sat_q;

  logic                          in_accept;
  logic                          advance;
  logic signed [SAMPLE_BITS-1:0] prev_eff;
  logic signed [HIST_BITS-1:0]   sample_ext;
  logic signed [HIST_BITS-1:0]   tap_eff [3];
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [OUTPUT_BITS-1:0] y;
  logic                          y_sat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q    <= '0;
      reverse_q <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_e'(cfg_ch.index))
        CFG_DIFF_GAIN:      coef_q.diff_gain      <= cfg_ch.data;
        CFG_FEEDBACK_ONE:   coef_q.feedback_one   <= cfg_ch.data;
        CFG_FEEDBACK_TWO:   coef_q.feedback_two   <= cfg_ch.data;
        CFG_FEEDBACK_THREE: coef_q.feedback_three <= cfg_ch.data;
        CFG_REVERSE_MODE:   reverse_q             <= cfg_ch.data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // advance the input register into the result register when it is free
  assign advance      = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready  = !s1_valid_q || advance;
  assign in_accept    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= in_ch.sample;
      s1_start_q  <= in_ch.line_start;
    end
  end

  // line start: history taken from the current sample
  assign sample_ext = HIST_BITS'(s1_sample_q);
  assign prev_eff   = s1_start_q ? s1_sample_q : prev_q;
  assign tap_eff[0] = s1_start_q ? sample_ext : tap_q[0];
  assign tap_eff[1] = s1_start_q ? sample_ext : tap_q[1];
  assign tap_eff[2] = s1_start_q ? sample_ext : tap_q[2];

  assign diff = reverse_q ? ((SAMPLE_BITS+1)'(prev_eff) - (SAMPLE_BITS+1)'(s1_sample_q))
                          : ((SAMPLE_BITS+1)'(s1_sample_q) - (SAMPLE_BITS+1)'(prev_eff));

  rgd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUTPUT_BITS (OUTPUT_BITS),
    .HIST_BITS   (HIST_BITS)
  ) u_datapath (
    .coef_i      (coef_q),
    .diff_i      (diff),
    .tap0_i      (tap_eff[0]),
    .tap1_i      (tap_eff[1]),
    .tap2_i      (tap_eff[2]),
    .filtered_o  (y),
    .saturated_o (y_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      tap_q[0] <= '0;
      tap_q[1] <= '0;
      tap_q[2] <= '0;
    end else if (advance) begin
      prev_q   <= s1_sample_q;
      tap_q[0] <= HIST_BITS'(y);
      tap_q[1] <= tap_eff[0];
      tap_q[2] <= tap_eff[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_filtered_q <= y;
      out_sat_q      <= y_sat;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.filtered  = out_filtered_q;
  assign out_ch.saturated = out_sat_q;

endmodule

[design/rgd_checker.sv]
module rgd_checker #(
  parameter int OUTPUT_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [OUTPUT_BITS-1:0] filtered_i,
  input logic                          saturated_i
);

  localparam logic signed [OUTPUT_BITS-1:0] MAXV = {1'b0, {(OUTPUT_BITS-1){1'b1}}};
  localparam logic signed [OUTPUT_BITS-1:0] MINV = {1'b1, {(OUTPUT_BITS-1){1'b0}}};

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] inflight_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(filtered_i) && $stable(saturated_i))
    else $error("stalled result changed");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> filtered_i == MAXV || filtered_i == MINV)
    else $error("saturated result not at a range limit");

  a_inflight_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q != 2'd3)
    else $error("more than two samples in flight");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 2'd0)
    else $error("result shown with no sample in flight");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> inflight_q == 2'd2)
    else $error("input stalled with room in the pipeline");

endmodule

bind recursive_gaussian_derivative_line rgd_checker #(
  .OUTPUT_BITS (OUTPUT_BITS)
) u_rgd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .filtered_i  (out_ch.filtered),
  .saturated_i (out_ch.saturated)
);
